### src/h2r_pkg.sv
// Shared constants and types for the HSV to RGB pixel converter.
// No dependencies; imported by h2r_lane and hsv_to_rgb_pixel.
package h2r_pkg;

   localparam int HUE_BITS   = 16;
   localparam int FRAC_BITS  = 12;
   localparam int COORD_BITS = 12;

   // Q12 saturation and value: 4096 is 1.0, the field is 13 bits wide
   localparam int          SV_W    = 13;
   localparam logic [12:0] Q12_ONE = 13'd4096;

   // tone input: 0..2^FRAC_BITS
   localparam int TN_W = FRAC_BITS + 1;
   // 1 - s*tn, scaled by 2^(12+FRAC_BITS)
   localparam int T_W  = SV_W + FRAC_BITS;
   // v * (1 - s*tn)
   localparam int NUM_W = 2 * SV_W + FRAC_BITS;
   // floor(255.5 * c) = (511 * num) >> (25 + FRAC_BITS)
   localparam int LEVEL_SHIFT = 25 + FRAC_BITS;
   localparam int SCALED_W    = NUM_W + 9;
   localparam int RAW_W       = SCALED_W - LEVEL_SHIFT;

   localparam int HPROD_W = HUE_BITS + 3;

   // fraction alignment from hue bits to FRAC_BITS
   localparam int FRAC_SHR = (HUE_BITS >= FRAC_BITS) ? (HUE_BITS - FRAC_BITS) : 0;
   localparam int FRAC_SHL = (HUE_BITS >= FRAC_BITS) ? 0 : (FRAC_BITS - HUE_BITS);
   localparam int FALIGN_W = HUE_BITS + FRAC_BITS;

   // hue sectors of 60 degrees
   localparam logic [2:0] SECTOR_RED_GREEN_UP   = 3'd0;
   localparam logic [2:0] SECTOR_RED_DOWN       = 3'd1;
   localparam logic [2:0] SECTOR_BLUE_UP        = 3'd2;
   localparam logic [2:0] SECTOR_GREEN_DOWN     = 3'd3;
   localparam logic [2:0] SECTOR_RED_UP         = 3'd4;

   // component lanes
   localparam int LANE_HI   = 0;
   localparam int LANE_LO   = 1;
   localparam int LANE_RISE = 2;
   localparam int LANE_FALL = 3;
   localparam int LANES     = 4;

   typedef struct packed {
      logic s2_ld;
      logic s3_ld;
      logic s4_ld;
   } h2r_stage_en_type;

endpackage

### src/h2r_lane.sv
// One color component lane: 1 - s*tn, times v, then scaled to 0..255.
// Three register stages, each loaded by its enable. Depends on h2r_pkg.
module h2r_lane import h2r_pkg::*; (
   input  logic                   clock,
   input  h2r_stage_en_type       en,
   input  logic [SV_W-1:0]        sat,
   input  logic [SV_W-1:0]        val,
   input  logic [TN_W-1:0]        tn,
   output logic [7:0]             level
);

   localparam logic [T_W-1:0] FULL = T_W'(1) << (12 + FRAC_BITS);

   logic [SV_W+TN_W-1:0] st_prod;
   logic [T_W-1:0]       t_in, t_ff;
   logic [SV_W-1:0]      v_ff;
   logic [NUM_W-1:0]     num_in, num_ff;
   logic [SCALED_W-1:0]  scaled;
   logic [RAW_W-1:0]     raw;
   logic [7:0]           level_in, level_ff;

   // stage 2: s * tn never exceeds FULL
   assign st_prod = sat * tn;
   assign t_in    = FULL - T_W'(st_prod);

   // stage 3
   assign num_in = NUM_W'(v_ff) * NUM_W'(t_ff);

   // stage 4: 511 * num as shift and subtract
   assign scaled   = (SCALED_W'(num_ff) << 9) - SCALED_W'(num_ff);
   assign raw      = scaled[SCALED_W-1:LEVEL_SHIFT];
   assign level_in = (raw > RAW_W'(255)) ? 8'd255 : raw[7:0];

   always_ff @(posedge clock) begin
      if (en.s2_ld) begin
         t_ff <= t_in;
         v_ff <= val;
      end
      if (en.s3_ld) begin
         num_ff <= num_in;
      end
      if (en.s4_ld) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

### src/hsv_to_rgb_pixel.sv
// HSV to packed RGB pixel converter, top level.
// Uses h2r_pkg and four h2r_lane instances (high, low, rising, falling).
//
// Usage:
//   Input channel req_*: pixel position plus hue (binary angle, one turn =
//   2^16), saturation and value in Q12 (4096 = 1.0, larger values clamp).
//   Result channel rsp_*: the same position and a 24-bit color, red in
//   23:16, green in 15:8, blue in 7:0. One result per transfer, in order.
//   An input transfer passes through the registered stages clamp/sector,
//   s*tn, v*t, scale and sector select to rsp_valid. Throughput: one pixel
//   per clock unless a stalled result has filled every stage; the limit is
//   one pass through each stage, fed by one multiplier per lane in s*tn, v*t.
//   Each full stage holds while its successor is full and stalled; req_ready
//   drops only once every stage holds a pixel, and empty stages close up
//   behind a stalled result. Nothing is dropped or repeated.
//   Reset (synchronous, active high) empties the pipeline; rsp_valid goes
//   low and req_ready is high in the next cycle.
module hsv_to_rgb_pixel import h2r_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_pixel_x,
   input  logic [COORD_BITS-1:0] req_pixel_y,
   input  logic [HUE_BITS-1:0]   req_hue_angle,
   input  logic [SV_W-1:0]       req_saturation,
   input  logic [SV_W-1:0]       req_brightness,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_out_x,
   output logic [COORD_BITS-1:0] rsp_out_y,
   output logic [23:0]           rsp_packed_color
);

   // valid bits per stage, stage 5 is the output register
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = !v5_ff || rsp_ready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // stage 1: clamp, sector and fraction
   logic [SV_W-1:0]       sat_in, val_in, sat_ff, val_ff;
   logic [HPROD_W-1:0]    hprod;
   logic [FALIGN_W-1:0]   falign;
   logic [FRAC_BITS-1:0]  frac_in, frac_ff;
   logic [2:0]            sector_in;
   logic [2:0]            sec1_ff, sec2_ff, sec3_ff, sec4_ff;
   logic [COORD_BITS-1:0] x1_ff, x2_ff, x3_ff, x4_ff;
   logic [COORD_BITS-1:0] y1_ff, y2_ff, y3_ff, y4_ff;

   assign sat_in    = (req_saturation > Q12_ONE) ? Q12_ONE : req_saturation;
   assign val_in    = (req_brightness > Q12_ONE) ? Q12_ONE : req_brightness;
   assign hprod     = HPROD_W'(req_hue_angle) * HPROD_W'(6);
   assign sector_in = hprod[HPROD_W-1:HUE_BITS];
   assign falign    = (FALIGN_W'(hprod[HUE_BITS-1:0]) >> FRAC_SHR) << FRAC_SHL;
   assign frac_in   = falign[FRAC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (rdy1) begin
         sat_ff  <= sat_in;
         val_ff  <= val_in;
         frac_ff <= frac_in;
         sec1_ff <= sector_in;
         x1_ff   <= req_pixel_x;
         y1_ff   <= req_pixel_y;
      end
      if (rdy2) begin
         sec2_ff <= sec1_ff;
         x2_ff   <= x1_ff;
         y2_ff   <= y1_ff;
      end
      if (rdy3) begin
         sec3_ff <= sec2_ff;
         x3_ff   <= x2_ff;
         y3_ff   <= y2_ff;
      end
      if (rdy4) begin
         sec4_ff <= sec3_ff;
         x4_ff   <= x3_ff;
         y4_ff   <= y3_ff;
      end
   end

   // stages 2 to 4: component lanes
   h2r_stage_en_type     lane_en;
   logic [TN_W-1:0]      tn   [LANES];
   logic [7:0]           lvl  [LANES];

   assign lane_en.s2_ld = rdy2;
   assign lane_en.s3_ld = rdy3;
   assign lane_en.s4_ld = rdy4;

   assign tn[LANE_HI]   = '0;
   assign tn[LANE_LO]   = TN_W'(1) << FRAC_BITS;
   assign tn[LANE_RISE] = (TN_W'(1) << FRAC_BITS) - TN_W'(frac_ff);
   assign tn[LANE_FALL] = TN_W'(frac_ff);

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      h2r_lane u_lane (
         .clock (clock),
         .en    (lane_en),
         .sat   (sat_ff),
         .val   (val_ff),
         .tn    (tn[i]),
         .level (lvl[i])
      );
   end

   // stage 5: place components by sector
   logic [7:0]            hi, lo, rise, fall;
   logic [23:0]           color_in, color_ff;
   logic [COORD_BITS-1:0] x5_ff, y5_ff;

   assign hi   = lvl[LANE_HI];
   assign lo   = lvl[LANE_LO];
   assign rise = lvl[LANE_RISE];
   assign fall = lvl[LANE_FALL];

   always_comb begin
      case (sec4_ff)
         SECTOR_RED_GREEN_UP: color_in = {hi,   rise, lo};
         SECTOR_RED_DOWN:     color_in = {fall, hi,   lo};
         SECTOR_BLUE_UP:      color_in = {lo,   hi,   rise};
         SECTOR_GREEN_DOWN:   color_in = {lo,   fall, hi};
         SECTOR_RED_UP:       color_in = {rise, lo,   hi};
         default:             color_in = {hi,   lo,   fall};
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         color_ff <= color_in;
         x5_ff    <= x4_ff;
         y5_ff    <= y4_ff;
      end
   end

   assign rsp_valid        = v5_ff;
   assign rsp_out_x        = x5_ff;
   assign rsp_out_y        = y5_ff;
   assign rsp_packed_color = color_ff;

endmodule
